>>> rtl/core/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types, constants and compare helper for the sorted-array priority
// queue: sizes, request and status codes, controller state and commands.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int DEPTH    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEVEL_W  = 4;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic ORDER_ASC  = 1'b0;
  localparam logic ORDER_DESC = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  // New value must go ahead of the held entry under the given order.
  function automatic logic goes_before(input logic signed [VALUE_W-1:0] val,
                                       input logic signed [VALUE_W-1:0] held,
                                       input logic                      mode);
    logic res;
    if (mode == ORDER_DESC) begin
      res = (held < val);
    end else begin
      res = (val < held);
    end
    return res;
  endfunction

endpackage

>>> rtl/core/sapq_ctrl.sv
// ----------------------------------------------------------------------------
// sapq_ctrl
// Controller: takes a request beat, enters the execute state and commits once the
// result register is free, and tracks the valid flag of the result beat.
// ----------------------------------------------------------------------------
module sapq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sapq_pkg::cmd_t cmd
);
  import sapq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = in_valid && (state_r == S_IDLE);
  assign cmd.commit  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/sapq_dp.sv
// ----------------------------------------------------------------------------
// sapq_dp
// Datapath: order register, request latch, sorted entry cells with per-cell
// compare and shift, entry count and result register.
// ----------------------------------------------------------------------------
module sapq_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sapq_pkg::cmd_t                         cmd,
  input  logic                                   cfg_we,
  input  logic                                   cfg_wdata,
  input  logic                                   in_req_type,
  input  logic signed [sapq_pkg::VALUE_W-1:0]    in_value,
  output logic signed [sapq_pkg::VALUE_W-1:0]    out_head_value,
  output logic        [sapq_pkg::STATUS_W-1:0]   out_status,
  output logic        [sapq_pkg::LEVEL_W-1:0]    out_level
);
  import sapq_pkg::*;

  logic                       order_r;
  logic                       req_r;
  logic signed [VALUE_W-1:0]  val_r;
  logic signed [VALUE_W-1:0]  ent_r   [DEPTH];
  logic signed [VALUE_W-1:0]  ent_nxt [DEPTH];
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic signed [VALUE_W-1:0]  head_r, head_nxt;
  logic [STATUS_W-1:0]        status_r, status_nxt;
  logic [LEVEL_W-1:0]         level_r;

  logic [DEPTH-1:0]           nb;
  logic [DEPTH:0]             after;
  logic                       full, empty;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Cells that the new value does not precede; insert lands behind the last.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      nb[j] = (CNT_W'(j) < count_r) && !goes_before(val_r, ent_r[j], order_r);
    end
    after[DEPTH] = 1'b1;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      after[i] = after[i+1] && !nb[i];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    count_nxt  = count_r;
    head_nxt   = '0;
    status_nxt = ST_OK;
    if (req_r == REQ_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CNT_W'(i) <= count_r) begin
            if (i == 0) begin
              if (after[0]) ent_nxt[i] = val_r;
            end else if (after[i-1]) begin
              ent_nxt[i] = ent_r[i-1];
            end else if (nb[i-1] && after[i]) begin
              ent_nxt[i] = val_r;
            end
          end
        end
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        head_nxt = ent_r[0];
        for (int i = 0; i < DEPTH - 1; i++) begin
          ent_nxt[i] = ent_r[i+1];
        end
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_ASC;
      count_r <= '0;
    end else begin
      if (cfg_we) order_r <= cfg_wdata;
      if (cmd.commit) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      val_r <= in_value;
    end
    if (cmd.commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
      head_r   <= head_nxt;
      status_r <= status_nxt;
      level_r  <= LEVEL_W'(count_nxt);
    end
  end

  assign out_head_value = head_r;
  assign out_status     = status_r;
  assign out_level      = level_r;

endmodule

>>> rtl/core/sorted_array_priority_queue_unit.sv
// Request beat is latched, state goes to execute, result register loads once it is free.
// No new request until the last commits; the execute step updates all cells in parallel.
// Next request is taken while the previous result beat still waits on out_ready.
// Reset (rst_n low, synchronous): queue empty, ascending order, no result pending.
// Entry contents are not cleared; only slots below the count affect any result.
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Priority queue held as a sorted array of signed values; insert and pop
// requests in, one result beat per request out.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_req_type,
  input  logic signed [sapq_pkg::VALUE_W-1:0]    in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sapq_pkg::VALUE_W-1:0]    out_head_value,
  output logic        [sapq_pkg::STATUS_W-1:0]   out_status,
  output logic        [sapq_pkg::LEVEL_W-1:0]    out_level,
  input  logic                                   cfg_we,
  input  logic                                   cfg_wdata
);
  import sapq_pkg::*;

  cmd_t cmd;

  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sapq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .out_head_value (out_head_value),
    .out_status     (out_status),
    .out_level      (out_level)
  );

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten while beat pending");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous still executing");

  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_level == LEVEL_W'(DEPTH)))
    else $error("full status with queue not full");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_level == '0 && out_head_value == '0))
    else $error("empty status with entries held");

endmodule
